>>> src/word_reverse_uppercase_filter_core_assert.svh
// Assertion macros for the word reverse / uppercase filter.
// Included by files that check their own logic; no other dependencies.
`ifndef WORD_REVERSE_UPPERCASE_FILTER_CORE_ASSERT_SVH
`define WORD_REVERSE_UPPERCASE_FILTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define WRUF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset
`define WRUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WRUF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define WRUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/wruf_pkg.sv
// Shared types, constants and the case-mapping function of the filter.
// No dependencies.
`timescale 1ns / 1ps

package wruf_pkg;

    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CHAR_W-1:0] SPACE_CODE  = 8'h20;
    localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_ENABLE = 2'd1;

    typedef struct packed {
        logic upper_enable;
        logic reverse_enable;
    } cfg_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] count;
    } seq_status_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_SPACE = 4'b1000
    } seq_state_t;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
            r = c - CASE_OFFSET;
        return r;
    endfunction

endpackage

>>> src/wruf_stack_mem.sv
// Word stack storage: one write port, one read port with registered data.
// Depends on nothing; widths come from parameters.
`timescale 1ns / 1ps

module wruf_stack_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write on push; on pop, read into a data register ahead of use
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/wruf_seq.sv
// Sequencer of the filter: push/pop control, stack count and output register.
// Depends on wruf_pkg; drives the stack memory through its ports.
`timescale 1ns / 1ps

module wruf_seq #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wruf_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [wruf_pkg::CHAR_W-1:0]       in_char,
    input  logic                              end_of_stream,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wruf_pkg::CHAR_W-1:0]       out_char,
    output logic                              last_of_run,
    output wruf_pkg::mem_ctrl_t               mem_ctrl,
    output logic [ADDR_W-1:0]                 wr_addr,
    output logic [wruf_pkg::CHAR_W-1:0]       wr_data,
    output logic [ADDR_W-1:0]                 rd_addr,
    input  logic [wruf_pkg::CHAR_W-1:0]       rd_data,
    output wruf_pkg::seq_status_t             status
);

    import wruf_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    seq_state_t         state_reg,       state_next;
    logic [COUNT_W-1:0] count_reg,       count_next;
    logic               flush_space_reg, flush_space_next;
    logic               out_valid_reg,   out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg,    out_char_next;
    logic               out_last_reg,    out_last_next;

    logic               slot_free;
    logic [COUNT_W-1:0] count_dec;
    logic [CHAR_W-1:0]  mapped_char;

    assign slot_free   = !out_valid_reg || out_ready;
    assign count_dec   = count_reg - COUNT_W'(1);
    assign mapped_char = cfg.upper_enable ? to_upper(in_char) : in_char;
    assign in_ready    = (state_reg == ST_IDLE) && slot_free;

    // Decide the next step of push, pop and emit
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        flush_space_next = flush_space_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        mem_ctrl         = '0;
        wr_addr          = count_reg[ADDR_W-1:0];
        wr_data          = mapped_char;
        rd_addr          = count_dec[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (end_of_stream)
                    begin
                        if (count_reg != '0)
                        begin
                            flush_space_next = 1'b0;
                            state_next       = ST_READ;
                        end
                    end
                    else if (in_char == SPACE_CODE)
                    begin
                        if (count_reg != '0)
                        begin
                            flush_space_next = 1'b1;
                            state_next       = ST_READ;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = SPACE_CODE;
                            out_last_next  = 1'b1;
                        end
                    end
                    else if (cfg.reverse_enable)
                    begin
                        // Push, drop once the stack is full
                        if (count_reg < DEPTH_C)
                        begin
                            mem_ctrl.wr_en = 1'b1;
                            count_next     = count_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = mapped_char;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                // Fetch the top of the stack
                mem_ctrl.rd_en = 1'b1;
                count_next     = count_dec;
                state_next     = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data;
                    out_last_next  = (count_reg == '0) && !flush_space_reg;
                    if (count_reg != '0)
                        state_next = ST_READ;
                    else if (flush_space_reg)
                        state_next = ST_SPACE;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SPACE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = SPACE_CODE;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            flush_space_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            flush_space_reg <= flush_space_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign last_of_run  = out_last_reg;
    assign status.busy  = (state_reg != ST_IDLE);
    assign status.count = count_reg;

endmodule

>>> src/word_reverse_uppercase_filter_core.sv
// Top level of the word reverse / uppercase filter: configuration registers,
// sequencer and stack memory. Depends on wruf_pkg, wruf_seq, wruf_stack_mem.
`timescale 1ns / 1ps

// Text filter taking one byte word per handshake. A byte that passes through
// or is pushed onto the word stack is taken while the sequencer is idle, so
// such words can be accepted back to back while the output keeps up. A space
// or end of stream with bytes pending starts a pop, in which each popped byte
// costs a read of the stack memory and then a load of the output register;
// a space is output after its word. No input is taken while a word is being
// popped. The stack memory needs no clearing pass after reset. Configuration
// registers: index 0 upper_enable, index 1 reverse_enable; other indexes are
// ignored and writes are always taken.

`include "word_reverse_uppercase_filter_core_assert.svh"

module word_reverse_uppercase_filter_core #(
    parameter int WORD_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wruf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [wruf_pkg::CHAR_W-1:0]       in_char,
    input  logic                              end_of_stream,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wruf_pkg::CHAR_W-1:0]       out_char,
    output logic                              last_of_run
);

    import wruf_pkg::*;

    localparam int ADDR_W = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

    logic        upper_enable_reg,   upper_enable_next;
    logic        reverse_enable_reg, reverse_enable_next;
    cfg_t        cfg;
    mem_ctrl_t   mem_ctrl;
    seq_status_t status;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CHAR_W-1:0] wr_data;
    logic [CHAR_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        upper_enable_next   = upper_enable_reg;
        reverse_enable_next = reverse_enable_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UPPER_ENABLE:   upper_enable_next   = cfg_data;
                REG_REVERSE_ENABLE: reverse_enable_next = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_enable_reg   <= 1'b0;
            reverse_enable_reg <= 1'b0;
        end
        else
        begin
            upper_enable_reg   <= upper_enable_next;
            reverse_enable_reg <= reverse_enable_next;
        end
    end

    assign cfg.upper_enable   = upper_enable_reg;
    assign cfg.reverse_enable = reverse_enable_reg;

    wruf_seq #(
        .DEPTH  (WORD_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .last_of_run   (last_of_run),
        .mem_ctrl      (mem_ctrl),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .status        (status)
    );

    wruf_stack_mem #(
        .DEPTH  (WORD_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (CHAR_W)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_ctrl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (mem_ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Stack count never passes the configured depth
    `WRUF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        status.count <= COUNT_W'(WORD_DEPTH), "word count beyond stack depth")
    // End of stream leaves nothing pending once input is taken again
    `WRUF_ASSERT_NEXT(a_eos_flush, clk, rst_n, in_valid && in_ready && end_of_stream,
        !in_ready || (status.count == '0), "pending word not flushed at end of stream")
    // A straight-through byte with nothing pending appears next cycle as a last word
    `WRUF_ASSERT_NEXT(a_pass_through, clk, rst_n,
        in_valid && in_ready && !end_of_stream && (in_char != SPACE_CODE) &&
        !reverse_enable_reg && (status.count == '0),
        out_valid && last_of_run, "pass-through byte not emitted")
    // Hold the input off while a word is being popped
    `WRUF_ASSERT_IMPL(a_busy_holds_input, clk, rst_n, status.busy, !in_ready,
        "input taken while a word is being popped")

endmodule
